// ===== src/dgsr_pkg.sv =====
// Package for the delayed gain switch ramp unit: widths, register map,
// selection codes and the packed word types of both channels.
// Has no dependencies; every other file of the block imports it.
`default_nettype none

package dgsr_pkg;

  localparam int GainW       = 32;
  localparam int CountW      = 24;
  localparam int MantBitsDef = 24;
  localparam int AddrW       = 5;
  localparam int DataW       = 32;

  typedef enum logic [2:0] {
    RegWaitSecond = 3'd0,
    RegWaitFirst  = 3'd1,
    RegGainFirst  = 3'd2,
    RegGainSecond = 3'd3,
    RegStepSecond = 3'd4,
    RegStepFirst  = 3'd5,
    RegRampEnable = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    SelNone   = 2'd0,
    SelFirst  = 2'd1,
    SelSecond = 2'd2
  } sel_e;

  typedef struct packed {
    logic condition;
    logic clear_timers;
  } in_word_t;

  typedef struct packed {
    logic signed [GainW-1:0] gain_now;
    logic        [1:0]       gain_selected;
  } out_word_t;

endpackage

`default_nettype wire

// ===== src/dgsr_ramp.sv =====
// One ramp step of an exponent-mantissa gain toward a target gain.
// Combinational: alignment shift, add or subtract, one-bit renormalize, clamp.
// Depends on dgsr_pkg for the gain width.
`default_nettype none

module dgsr_ramp import dgsr_pkg::*; #(
  parameter int MantBits = MantBitsDef
) (
  input  wire logic [GainW-1:0] src_i,
  input  wire logic [GainW-1:0] dst_i,
  input  wire logic [GainW-1:0] step_i,
  output logic      [GainW-1:0] gain_o
);

  localparam int ExpW     = GainW - MantBits;
  localparam int QuarterI = 1 << (MantBits - 2);
  localparam int MantMaxI = (1 << (MantBits - 1)) - 1;

  logic        [MantBits-1:0] src_m, dst_m, step_m;
  logic signed [ExpW-1:0]     se, de, te;
  logic signed [ExpW:0]       sft, ae, de_x, e_dn, e_up;
  logic        [ExpW:0]       sh_amt;
  logic        [MantBits-1:0] cm, wrk_raw, wrk, mu;
  logic signed [MantBits+1:0] kx_dn, kx2;
  logic        [MantBits:0]   ku;
  logic                       exp_lt, exp_eq;

  assign src_m  = src_i[MantBits-1:0];
  assign dst_m  = dst_i[MantBits-1:0];
  assign step_m = step_i[MantBits-1:0];
  assign se     = $signed(src_i[GainW-1:MantBits]);
  assign de     = $signed(dst_i[GainW-1:MantBits]);
  assign te     = $signed(step_i[GainW-1:MantBits]);
  assign sft    = {se[ExpW-1], se} - {te[ExpW-1], te};
  assign de_x   = {de[ExpW-1], de};

  always_comb begin
    sh_amt  = '0;
    cm      = src_m;
    ae      = {se[ExpW-1], se};
    wrk_raw = step_m;
    if (sft <= 0) begin
      sh_amt = $unsigned(-sft);
      if (sh_amt >= (ExpW+1)'(MantBits)) begin
        wrk_raw = '0;
      end else begin
        wrk_raw = step_m >> sh_amt;
      end
    end else begin
      sh_amt = $unsigned(sft);
      if (sh_amt >= (ExpW+1)'(MantBits)) begin
        cm = '0;
      end else begin
        cm = src_m >> sh_amt;
      end
      ae = {te[ExpW-1], te};
    end
  end

  assign wrk    = (wrk_raw == '0) ? MantBits'(1) : wrk_raw;
  assign exp_lt = ae < de_x;
  assign exp_eq = ae == de_x;

  always_comb begin
    kx_dn = $signed({2'b00, cm}) - $signed({2'b00, wrk});
    kx2   = kx_dn;
    e_dn  = ae;
    ku    = {1'b0, cm} + {1'b0, wrk};
    mu    = ku[MantBits-1:0];
    e_up  = ae;
    gain_o = dst_i;
    if (src_i == dst_i || step_i == '0) begin
      gain_o = dst_i;
    end else if (exp_lt || (exp_eq && cm > dst_m)) begin
      if (kx_dn < (MantBits+2)'(QuarterI) && exp_lt) begin
        kx2  = kx_dn <<< 1;
        e_dn = ae + (ExpW+1)'(1);
      end
      if (kx2 <= 0) begin
        gain_o = dst_i;
      end else if (e_dn == de_x && kx2[MantBits-1:0] <= dst_m) begin
        gain_o = dst_i;
      end else begin
        gain_o = {e_dn[ExpW-1:0], kx2[MantBits-1:0]};
      end
    end else begin
      if (ku > (MantBits+1)'(MantMaxI)) begin
        mu   = ku[MantBits:1];
        e_up = ae - (ExpW+1)'(1);
      end
      if (e_up < de_x || (e_up == de_x && mu >= dst_m)) begin
        gain_o = dst_i;
      end else begin
        gain_o = {e_up[ExpW-1:0], mu};
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/delayed_gain_switch_ramp_unit.sv =====
// Top level of the delayed gain switch ramp unit: configuration registers,
// delay counters, gain state and a two-entry output stage.
// Depends on dgsr_pkg and dgsr_ramp.
`default_nettype none

// The unit takes one input word per clock cycle and returns one result word
// for each, in order. A word's gain update is a combinational path from
// the gain register through the ramp step (alignment shifter, mantissa adder
// and clamp compare) back into the gain register. Results leave through an
// output register backed by a skid register, so input words keep being taken
// while one result waits; input ready drops only when both hold a word.
// Each result is registered. The user must write registers over the APB
// port only while the unit is idle; the unit itself does not enforce it.
module delayed_gain_switch_ramp_unit import dgsr_pkg::*; #(
  parameter int MantBits = MantBitsDef
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire in_word_t         in_word_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output out_word_t             out_word_o,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready
);

  logic [CountW-1:0] wait_second_q, wait_first_q;
  logic [GainW-1:0]  gain_first_q, gain_second_q, step_second_q, step_first_q;
  logic              ramp_en_q;

  logic [GainW-1:0]  gain_q, gain_d;
  logic [CountW-1:0] cnt_second_q, cnt_second_d, cnt_first_q, cnt_first_d;
  sel_e              sel_q, sel_d;

  logic              out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  out_word_t         out_word_q, out_word_d, skid_word_q, skid_word_d, res_word;

  logic              in_fire, out_pop, cfg_wr;
  reg_idx_e          reg_idx;
  logic [GainW-1:0]  ramp_dst, ramp_step, ramp_gain;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wait_second_q <= '0;
      wait_first_q  <= '0;
      gain_first_q  <= '0;
      gain_second_q <= '0;
      step_second_q <= '0;
      step_first_q  <= '0;
      ramp_en_q     <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        RegWaitSecond: wait_second_q <= pwdata[CountW-1:0];
        RegWaitFirst:  wait_first_q  <= pwdata[CountW-1:0];
        RegGainFirst:  gain_first_q  <= pwdata[GainW-1:0];
        RegGainSecond: gain_second_q <= pwdata[GainW-1:0];
        RegStepSecond: step_second_q <= pwdata[GainW-1:0];
        RegStepFirst:  step_first_q  <= pwdata[GainW-1:0];
        RegRampEnable: ramp_en_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      RegWaitSecond: prdata = DataW'(wait_second_q);
      RegWaitFirst:  prdata = DataW'(wait_first_q);
      RegGainFirst:  prdata = DataW'(gain_first_q);
      RegGainSecond: prdata = DataW'(gain_second_q);
      RegStepSecond: prdata = DataW'(step_second_q);
      RegStepFirst:  prdata = DataW'(step_first_q);
      RegRampEnable: prdata = DataW'(ramp_en_q);
      default:       prdata = '0;
    endcase
  end

  assign ramp_dst  = in_word_i.condition ? gain_second_q : gain_first_q;
  assign ramp_step = in_word_i.condition ? step_second_q : step_first_q;

  dgsr_ramp #(
    .MantBits(MantBits)
  ) u_ramp (
    .src_i (gain_q),
    .dst_i (ramp_dst),
    .step_i(ramp_step),
    .gain_o(ramp_gain)
  );

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    gain_d       = gain_q;
    cnt_second_d = cnt_second_q;
    cnt_first_d  = cnt_first_q;
    sel_d        = sel_q;
    if (in_fire) begin
      if (in_word_i.clear_timers) begin
        cnt_second_d = '0;
        cnt_first_d  = '0;
      end else if (in_word_i.condition) begin
        if (cnt_second_q >= wait_second_q) begin
          gain_d      = ramp_en_q ? ramp_gain : gain_second_q;
          sel_d       = SelSecond;
          cnt_first_d = '0;
        end else begin
          cnt_second_d = cnt_second_q + CountW'(1);
        end
      end else begin
        if (cnt_first_q >= wait_first_q) begin
          gain_d       = ramp_en_q ? ramp_gain : gain_first_q;
          sel_d        = SelFirst;
          cnt_second_d = '0;
        end else begin
          cnt_first_d = cnt_first_q + CountW'(1);
        end
      end
    end
  end

  assign res_word.gain_now      = $signed(gain_d);
  assign res_word.gain_selected = sel_d;

  assign out_pop = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_word_d   = out_word_q;
    skid_word_d  = skid_word_q;
    if (in_fire) begin
      if (!out_valid_q || out_pop) begin
        out_valid_d = 1'b1;
        out_word_d  = res_word;
      end else begin
        skid_valid_d = 1'b1;
        skid_word_d  = res_word;
      end
    end else if (out_pop) begin
      if (skid_valid_q) begin
        out_word_d   = skid_word_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q       <= '0;
      cnt_second_q <= '0;
      cnt_first_q  <= '0;
      sel_q        <= SelNone;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      gain_q       <= gain_d;
      cnt_second_q <= cnt_second_d;
      cnt_first_q  <= cnt_first_d;
      sel_q        <= sel_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_word_q  <= out_word_d;
    skid_word_q <= skid_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  // A full skid register always sits behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held with empty output register");

  // A clear word zeroes both counters and leaves the gain alone.
  a_clear_counters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_word_i.clear_timers) |=> (cnt_second_q == '0 && cnt_first_q == '0))
    else $error("counters not cleared");

  a_clear_keeps_gain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_word_i.clear_timers) |=> $stable(gain_q))
    else $error("gain changed on a clear word");

  // Once a gain has been selected, the selection never returns to none.
  a_sel_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sel_q != SelNone) |=> (sel_q != SelNone))
    else $error("selection fell back to none");

  // The gain only moves when a word is accepted.
  a_gain_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_fire |=> $stable(gain_q))
    else $error("gain changed without an accepted word");

endmodule

`default_nettype wire

// ===== test/delayed_gain_switch_ramp_unit_tb.sv =====
// Testbench for delayed_gain_switch_ramp_unit: a directed table followed by random
// condition runs and setups, each result checked against the table or a local
// gain predictor. Depends on dgsr_pkg and the unit's RTL.
`timescale 1ns / 1ps

module testbench;
  import dgsr_pkg::*;

  localparam int          MB          = MantBitsDef;
  localparam logic [31:0] MantMask    = (32'd1 << MB) - 32'd1;
  localparam longint      MantQuarter = longint'(1) << (MB - 2);
  localparam longint      MantMax     = (longint'(1) << (MB - 1)) - 1;

  typedef struct {
    logic        is_setup;
    reg_idx_e    idx;
    logic [31:0] val;
    in_word_t    w;
    logic        typed;
    out_word_t   want;
  } plan_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  in_word_t         in_word_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  out_word_t        out_word_o;
  logic             psel        = 1'b0;
  logic             penable     = 1'b0;
  logic             pwrite      = 1'b0;
  logic [AddrW-1:0] paddr       = '0;
  logic [DataW-1:0] pwdata      = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  logic [23:0] wait_second = '0;
  logic [23:0] wait_first  = '0;
  logic [31:0] gain_first  = '0;
  logic [31:0] gain_second = '0;
  logic [31:0] step_second = '0;
  logic [31:0] step_first  = '0;
  logic        ramp_on     = 1'b0;

  logic [31:0] cur_gain   = '0;
  logic [23:0] cnt_second = '0;
  logic [23:0] cnt_first  = '0;
  logic [1:0]  cur_sel    = SelNone;

  out_word_t gain_words_due[$];
  plan_row_t plan[$];
  out_word_t want_word;
  int        fail_count    = 0;
  int        send_idle_pct = 24;
  int        recv_idle_pct = 70;

  delayed_gain_switch_ramp_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic longint gain_exponent(logic [31:0] g);
    return longint'($signed(g)) >>> MB;
  endfunction

  function automatic logic [31:0] pack_gain(longint e, longint m);
    logic [63:0] t;
    t = (e << MB) | (m & {32'd0, MantMask});
    return t[31:0];
  endfunction

  function automatic logic [31:0] ramp_gain(logic [31:0] src, logic [31:0] dst,
                                            logic [31:0] stp);
    longint      se, de, te, sft, wrk, kx;
    logic [31:0] cur, sm, r;
    if (src == dst || stp == 32'd0) return dst;
    cur = src;
    se  = gain_exponent(src);
    de  = gain_exponent(dst);
    te  = gain_exponent(stp);
    sft = se - te;
    if (sft <= 0) begin
      wrk = (-sft >= MB) ? 0 : ((stp & MantMask) >> (-sft));
    end else begin
      sm  = (sft >= MB) ? 32'd0 : ((src & MantMask) >> sft);
      se  = te;
      cur = pack_gain(se, sm);
      wrk = stp & MantMask;
    end
    if (wrk == 0) wrk = 1;
    if (se < de || (se == de && $signed(cur) > $signed(dst))) begin
      kx = longint'(cur & MantMask) - wrk;
      if (kx < MantQuarter && se < de) begin
        kx = kx * 2;
        se = se + 1;
      end
      if (kx <= 0) return dst;
      r = pack_gain(se, kx);
      if (se == de && $signed(r) <= $signed(dst)) return dst;
      return r;
    end
    kx = longint'(cur & MantMask) + wrk;
    if (kx > MantMax) begin
      kx = kx >>> 1;
      se = se - 1;
    end
    r = pack_gain(se, kx);
    if (se < de || (se == de && $signed(r) >= $signed(dst))) return dst;
    return r;
  endfunction

  function automatic out_word_t next_gain_word(in_word_t w);
    out_word_t o;
    if (w.clear_timers) begin
      cnt_second = '0;
      cnt_first  = '0;
    end else if (w.condition) begin
      if (cnt_second >= wait_second) begin
        cur_gain  = ramp_on ? ramp_gain(cur_gain, gain_second, step_second) : gain_second;
        cur_sel   = SelSecond;
        cnt_first = '0;
      end else begin
        cnt_second = cnt_second + 24'd1;
      end
    end else begin
      if (cnt_first >= wait_first) begin
        cur_gain   = ramp_on ? ramp_gain(cur_gain, gain_first, step_first) : gain_first;
        cur_sel    = SelFirst;
        cnt_second = '0;
      end else begin
        cnt_first = cnt_first + 24'd1;
      end
    end
    o.gain_now      = cur_gain;
    o.gain_selected = cur_sel;
    return o;
  endfunction

  task automatic apb_write(reg_idx_e idx, logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      RegWaitSecond: wait_second = val[23:0];
      RegWaitFirst:  wait_first  = val[23:0];
      RegGainFirst:  gain_first  = val;
      RegGainSecond: gain_second = val;
      RegStepSecond: step_second = val;
      RegStepFirst:  step_first  = val;
      RegRampEnable: ramp_on     = val[0];
      default: ;
    endcase
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (gain_words_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_word(in_word_t w, logic typed, out_word_t want);
    out_word_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    pred = next_gain_word(w);
    gain_words_due.push_back(typed ? want : pred);
  endtask

  function automatic plan_row_t row_word(logic c, logic k);
    plan_row_t p;
    p = '{is_setup: 1'b0, idx: RegWaitSecond, val: '0, w: '0, typed: 1'b0, want: '0};
    p.w.condition    = c;
    p.w.clear_timers = k;
    return p;
  endfunction

  function automatic plan_row_t row_typed(logic c, logic k, logic [31:0] g, sel_e s);
    plan_row_t p;
    p = row_word(c, k);
    p.typed              = 1'b1;
    p.want.gain_now      = g;
    p.want.gain_selected = s;
    return p;
  endfunction

  function automatic plan_row_t row_setup(reg_idx_e idx, logic [31:0] val);
    plan_row_t p;
    p = row_word(1'b0, 1'b0);
    p.is_setup = 1'b1;
    p.idx      = idx;
    p.val      = val;
    return p;
  endfunction

  function automatic logic [31:0] pick_gain();
    logic [7:0] e;
    e = 8'($urandom_range(6)) - 8'd3;
    case ($urandom_range(4))
      0: return $urandom;
      1: begin
        case ($urandom_range(3))
          0: return 32'h8000_0000;
          1: return 32'h7FFF_FFFF;
          2: return 32'h0000_0000;
          default: return 32'hFFFF_FFFF;
        endcase
      end
      default: return {e, 24'($urandom_range(24'h7FFFFF, 24'h400000))};
    endcase
  endfunction

  function automatic logic [31:0] pick_step();
    logic [7:0] e;
    e = 8'($urandom_range(10)) - 8'd2;
    case ($urandom_range(5))
      0: return $urandom;
      1: return ($urandom_range(1) != 0) ? 32'd0 : 32'h7FFF_FFFF;
      default: return {e, 24'($urandom)};
    endcase
  endfunction

  function automatic logic [31:0] pick_wait();
    logic [23:0] v;
    v = ($urandom_range(15) == 0) ? 24'hFFFFFF : 24'($urandom_range(5));
    return {8'($urandom), v};
  endfunction

  task automatic load_random_setup();
    apb_write(RegWaitSecond, pick_wait());
    apb_write(RegWaitFirst,  pick_wait());
    apb_write(RegGainFirst,  pick_gain());
    apb_write(RegGainSecond, pick_gain());
    apb_write(RegStepSecond, pick_step());
    apb_write(RegStepFirst,  pick_step());
    apb_write(RegRampEnable, {31'($urandom), 1'($urandom_range(3) != 0)});
  endtask

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (gain_words_due.size() == 0) begin
        $error("result word arrived with none expected");
        fail_count++;
      end else begin
        want_word = gain_words_due.pop_front();
        if (out_word_o.gain_now !== want_word.gain_now) begin
          $error("gain_now: expected %h, got %h", want_word.gain_now, out_word_o.gain_now);
          fail_count++;
        end
        if (out_word_o.gain_selected !== want_word.gain_selected) begin
          $error("gain_selected: expected %0d, got %0d",
                 want_word.gain_selected, out_word_o.gain_selected);
          fail_count++;
        end
      end
    end
  end

  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic run_cond;
    int   run_left;
    int   n;

    plan.push_back(row_typed(1'b0, 1'b0, 32'h0000_0000, SelFirst));
    plan.push_back(row_typed(1'b1, 1'b1, 32'h0000_0000, SelFirst));
    plan.push_back(row_typed(1'b1, 1'b0, 32'h0000_0000, SelSecond));
    plan.push_back(row_setup(RegWaitSecond, 32'd2));
    plan.push_back(row_setup(RegWaitFirst, 32'h00FF_FFFF));
    plan.push_back(row_setup(RegGainSecond, 32'h7FFF_FFFF));
    plan.push_back(row_setup(RegGainFirst, 32'h8000_0000));
    plan.push_back(row_typed(1'b1, 1'b0, 32'h0000_0000, SelSecond));
    plan.push_back(row_typed(1'b1, 1'b0, 32'h0000_0000, SelSecond));
    plan.push_back(row_typed(1'b1, 1'b0, 32'h7FFF_FFFF, SelSecond));
    plan.push_back(row_typed(1'b0, 1'b0, 32'h7FFF_FFFF, SelSecond));
    plan.push_back(row_typed(1'b0, 1'b1, 32'h7FFF_FFFF, SelSecond));
    plan.push_back(row_setup(RegWaitFirst, 32'd0));
    plan.push_back(row_setup(RegWaitSecond, 32'd0));
    plan.push_back(row_typed(1'b0, 1'b0, 32'h8000_0000, SelFirst));
    plan.push_back(row_setup(RegRampEnable, 32'd1));
    plan.push_back(row_setup(RegStepSecond, 32'h7FFF_FFFF));
    plan.push_back(row_setup(RegStepFirst, 32'h8000_0000));
    plan.push_back(row_word(1'b1, 1'b0));
    plan.push_back(row_word(1'b0, 1'b0));
    plan.push_back(row_setup(RegStepFirst, 32'd0));
    plan.push_back(row_word(1'b1, 1'b0));
    plan.push_back(row_word(1'b0, 1'b0));
    plan.push_back(row_setup(RegGainFirst, 32'h807F_0000));
    plan.push_back(row_setup(RegGainSecond, 32'h80FF_0000));
    plan.push_back(row_setup(RegStepSecond, 32'h8010_0000));
    plan.push_back(row_setup(RegStepFirst, 32'h0120_0000));
    plan.push_back(row_setup(RegRampEnable, 32'd0));
    plan.push_back(row_word(1'b0, 1'b0));
    plan.push_back(row_setup(RegRampEnable, 32'd1));
    plan.push_back(row_word(1'b1, 1'b0));
    plan.push_back(row_word(1'b1, 1'b0));
    plan.push_back(row_setup(RegGainFirst, 32'h0140_0000));
    plan.push_back(row_setup(RegGainSecond, 32'h0260_0000));
    plan.push_back(row_setup(RegStepSecond, 32'h0200_8000));
    plan.push_back(row_setup(RegStepFirst, 32'h0300_1000));
    plan.push_back(row_setup(RegWaitFirst, 32'd1));
    repeat (3) plan.push_back(row_word(1'b0, 1'b0));
    plan.push_back(row_word(1'b0, 1'b1));
    repeat (4) plan.push_back(row_word(1'b1, 1'b0));
    repeat (3) plan.push_back(row_word(1'b0, 1'b0));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i]) begin
      if (plan[i].is_setup) begin
        drain_results();
        apb_write(plan[i].idx, plan[i].val);
      end else begin
        send_word(plan[i].w, plan[i].typed, plan[i].want);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 24;
          recv_idle_pct = 70;
        end
        1: begin
          send_idle_pct = 70;
          recv_idle_pct = 24;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      run_left = 0;
      run_cond = 1'b0;
      for (n = 0; n < 340; n++) begin
        if (n % 68 == 0) begin
          drain_results();
          load_random_setup();
        end
        if (run_left == 0) begin
          run_cond = ~run_cond;
          run_left = ($urandom_range(4) == 0) ? 1 : $urandom_range(12, 1);
        end
        run_left--;
        send_word('{condition: ($urandom_range(9) == 0) ? 1'($urandom) : run_cond,
                    clear_timers: ($urandom_range(19) == 0)},
                  1'b0, '0);
      end
    end

    drain_results();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
